// File: rtl/core/scene_cut_detector_unit_assert.svh
// Assertion macros shared by the scene cut detector RTL.
`ifndef SCENE_CUT_DETECTOR_UNIT_ASSERT_SVH
`define SCENE_CUT_DETECTOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SCD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scene cut detector: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scene cut detector: assertion failed");

`endif

// File: rtl/core/scd_pkg.sv
// Shared constants for the scene cut detector.
package scd_pkg;

    localparam int LEVELS_DEF   = 8;
    localparam int LEVELS_MAX   = 8;

    localparam int ORDER_W      = 24;
    localparam int ACT_W        = 16;
    localparam int PSNR_W       = 16;
    localparam int LAYER_W      = 3;
    localparam int BD_W         = 5;
    localparam int GOP_W        = 7;
    localparam int CUT_W        = 26;

    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 7;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BIT_DEPTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GOP_SIZE  = 1'd1;

    localparam logic [BD_W-1:0]  BIT_DEPTH_RST = 5'd10;
    localparam logic [GOP_W-1:0] GOP_SIZE_RST  = 7'd32;

    // Activity jump: act * 64 > prev * 181
    localparam int ACT_PROD_W = 24;
    localparam logic [7:0] ACT_MUL_CUR  = 8'd64;
    localparam logic [7:0] ACT_MUL_PREV = 8'd181;

    // 4.5 dB in Q8.8
    localparam logic [PSNR_W-1:0] PSNR_JUMP_Q8 = 16'd1152;

    // Low-activity threshold is 2^(bit_depth - 6)
    localparam logic [BD_W-1:0] LOW_ACT_BD_OFS = 5'd6;

    localparam logic signed [CUT_W-1:0] CUT_RESET_ORDER = -26'sd100;

endpackage

// File: rtl/core/scene_cut_detector_unit.sv
// Scene cut detector top level: cut decision, cut spacing, per-layer refresh.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one first-pass statistics
//   record per transfer, in ascending picture order. Output channel
//   (out_valid / out_stall) returns exactly one result per record:
//   new_scene (accepted cut at this frame) and refresh (this layer's rate
//   parameters must be refreshed).
//   A record's result is registered: into the result register when that
//   is free or being read, else into the skid entry. Throughput: one record
//   per cycle while in_stall is low; the whole decision is a single layer of
//   compare logic between the state registers and the result register.
//   A result register plus a one-entry skid buffer part the two sides, so a
//   record is still taken while one result waits. in_stall rises only while
//   the skid entry is occupied, i.e. after the receiver has held out_stall
//   with two results pending; it is a register output.
//   Reset (rst_n low, async) clears the cut history (last cut at -100),
//   previous activity / intra PSNR, all refresh flags and both result slots;
//   bit_depth returns to 10 and gop_size to 32. The user must write the
//   configuration (cfg_we, cfg_index, cfg_data) only while idle; no guard.
module scene_cut_detector_unit #(
    parameter int LEVELS = scd_pkg::LEVELS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration write port
    input  logic                           cfg_we,
    input  logic [scd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [scd_pkg::CFG_DATA_W-1:0] cfg_data,
    // input channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [scd_pkg::ORDER_W-1:0]    pic_order,
    input  logic [scd_pkg::ACT_W-1:0]      activity,
    input  logic [scd_pkg::PSNR_W-1:0]     psnr_q8,
    input  logic                           intra,
    input  logic [scd_pkg::LAYER_W-1:0]    layer,
    // output channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           new_scene,
    output logic                           refresh
);
    import scd_pkg::*;

    localparam int IDX_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam logic [LAYER_W:0] LEVELS_CNT = (LAYER_W+1)'(LEVELS);
    localparam logic [LEVELS-1:0] ALL_FLAGS = {LEVELS{1'b1}};

    // configuration
    logic [BD_W-1:0]  bit_depth_reg;
    logic [GOP_W-1:0] gop_size_reg;

    // decision state
    logic [ACT_W-1:0]         prev_activity_reg, prev_activity_next;
    logic [PSNR_W-1:0]        prev_intra_psnr_reg, prev_intra_psnr_next;
    logic signed [CUT_W-1:0]  last_cut_order_reg, last_cut_order_next;
    logic [LEVELS-1:0]        refresh_pending_reg, refresh_pending_next;

    // result register and skid entry
    logic out_valid_reg, out_valid_next;
    logic out_new_scene_reg, out_new_scene_next;
    logic out_refresh_reg, out_refresh_next;
    logic skid_valid_reg, skid_valid_next;
    logic skid_new_scene_reg, skid_new_scene_next;
    logic skid_refresh_reg, skid_refresh_next;

    logic in_xfer, out_xfer;

    // decision datapath
    logic [BD_W-1:0]        shift_c;
    logic                   low_act_c;
    logic [ACT_PROD_W-1:0]  cur_prod_c, prev_prod_c;
    logic                   jump_c;
    logic [PSNR_W-1:0]      pdiff_c;
    logic                   intra_cut_c;
    logic                   raw_cut_c;
    logic signed [CUT_W:0]  min_order_c;
    logic signed [CUT_W:0]  order_ext_c;
    logic                   accept_c;
    logic                   layer_ok_c;
    logic [IDX_W-1:0]       layer_idx_c;
    logic [LEVELS-1:0]      pending_set_c;
    logic                   refresh_c;

    assign in_stall  = skid_valid_reg;
    assign in_xfer   = in_valid && !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign new_scene = out_new_scene_reg;
    assign refresh   = out_refresh_reg;
    assign out_xfer  = out_valid_reg && !out_stall;

    always_comb
    begin
        // low activity (layer 0 or 1): thresholds of 2^16 and above pass every frame
        shift_c   = (bit_depth_reg >= LOW_ACT_BD_OFS) ? bit_depth_reg - LOW_ACT_BD_OFS : '0;
        low_act_c = (layer <= LAYER_W'(1)) &&
                    ((shift_c >= BD_W'(ACT_W)) ||
                     ({1'b0, activity} <= ((ACT_W+1)'(1) << shift_c[3:0])));

        cur_prod_c  = ACT_PROD_W'(activity) * ACT_PROD_W'(ACT_MUL_CUR);
        prev_prod_c = ACT_PROD_W'(prev_activity_reg) * ACT_PROD_W'(ACT_MUL_PREV);
        jump_c      = cur_prod_c > prev_prod_c;

        pdiff_c     = (psnr_q8 >= prev_intra_psnr_reg) ? psnr_q8 - prev_intra_psnr_reg
                                                       : prev_intra_psnr_reg - psnr_q8;
        intra_cut_c = intra && (activity > prev_activity_reg) && (pdiff_c > PSNR_JUMP_Q8);

        raw_cut_c   = jump_c || low_act_c || intra_cut_c;

        // minimum spacing is half the group size
        min_order_c = {last_cut_order_reg[CUT_W-1], last_cut_order_reg} +
                      $signed({(CUT_W+1-(GOP_W-1))'(0), gop_size_reg[GOP_W-1:1]});
        order_ext_c = $signed({(CUT_W+1-ORDER_W)'(0), pic_order});
        accept_c    = raw_cut_c && (order_ext_c >= min_order_c);

        pending_set_c = accept_c ? ALL_FLAGS : refresh_pending_reg;
        layer_ok_c    = {1'b0, layer} < LEVELS_CNT;
        layer_idx_c   = IDX_W'(layer);
        refresh_c     = layer_ok_c && pending_set_c[layer_idx_c];

        prev_activity_next   = prev_activity_reg;
        prev_intra_psnr_next = prev_intra_psnr_reg;
        last_cut_order_next  = last_cut_order_reg;
        refresh_pending_next = refresh_pending_reg;
        if (in_xfer)
        begin
            prev_activity_next = activity;
            if (intra)
            begin
                prev_intra_psnr_next = psnr_q8;
            end
            if (accept_c)
            begin
                last_cut_order_next = $signed({(CUT_W-ORDER_W)'(0), pic_order});
            end
            refresh_pending_next = pending_set_c;
            if (layer_ok_c)
            begin
                refresh_pending_next[layer_idx_c] = 1'b0;
            end
        end
    end

    // result slot and skid entry
    always_comb
    begin
        out_valid_next      = out_valid_reg && !out_xfer;
        out_new_scene_next  = out_new_scene_reg;
        out_refresh_next    = out_refresh_reg;
        skid_valid_next     = skid_valid_reg;
        skid_new_scene_next = skid_new_scene_reg;
        skid_refresh_next   = skid_refresh_reg;

        if (skid_valid_reg && out_xfer)
        begin
            out_valid_next     = 1'b1;
            out_new_scene_next = skid_new_scene_reg;
            out_refresh_next   = skid_refresh_reg;
            skid_valid_next    = 1'b0;
        end
        else if (in_xfer)
        begin
            if (!out_valid_reg || out_xfer)
            begin
                out_valid_next     = 1'b1;
                out_new_scene_next = accept_c;
                out_refresh_next   = refresh_c;
            end
            else
            begin
                skid_valid_next     = 1'b1;
                skid_new_scene_next = accept_c;
                skid_refresh_next   = refresh_c;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_depth_reg       <= BIT_DEPTH_RST;
            gop_size_reg        <= GOP_SIZE_RST;
            prev_activity_reg   <= '0;
            prev_intra_psnr_reg <= '0;
            last_cut_order_reg  <= CUT_RESET_ORDER;
            refresh_pending_reg <= '0;
            out_valid_reg       <= 1'b0;
            skid_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_BIT_DEPTH: bit_depth_reg <= cfg_data[BD_W-1:0];
                    REG_GOP_SIZE:  gop_size_reg  <= cfg_data[GOP_W-1:0];
                    default:       ;
                endcase
            end
            prev_activity_reg   <= prev_activity_next;
            prev_intra_psnr_reg <= prev_intra_psnr_next;
            last_cut_order_reg  <= last_cut_order_next;
            refresh_pending_reg <= refresh_pending_next;
            out_valid_reg       <= out_valid_next;
            skid_valid_reg      <= skid_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        out_new_scene_reg  <= out_new_scene_next;
        out_refresh_reg    <= out_refresh_next;
        skid_new_scene_reg <= skid_new_scene_next;
        skid_refresh_reg   <= skid_refresh_next;
    end

`include "scene_cut_detector_unit_assert.svh"

    // skid entry only fills behind a waiting result
    `SCD_ASSERT_NOW(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg)
    `SCD_ASSERT_NOW(a_skid_fill_cause, clk, rst_n, $rose(skid_valid_reg),
        $past(out_valid_reg && out_stall))
    // an accepted cut becomes the new spacing reference
    `SCD_ASSERT_NEXT(a_cut_recorded, clk, rst_n, in_xfer && accept_c,
        last_cut_order_reg == $signed({(CUT_W-ORDER_W)'(0), $past(pic_order)}))

endmodule

// File: tb/testbench.sv
// Self-checking testbench for scene_cut_detector_unit: random and directed frame statistics.
`timescale 1ns / 1ps

module testbench;
    import scd_pkg::*;

    localparam int LEVELS            = LEVELS_DEF;
    localparam int NUM_SETTINGS      = 8;
    localparam int ITEMS_PER_SETTING = 240;
    localparam int LONG_HOLD         = 80;    // receiver hold-off that backs the block up
    localparam int HOLD_SPACING      = 500;   // results between long hold-offs
    localparam int WATCHDOG_LIMIT    = 2000;  // cycles without any transfer

    // One frame statistics record as it crosses the input channel
    typedef struct packed {
        logic [ORDER_W-1:0] order;
        logic [ACT_W-1:0]   act;
        logic [PSNR_W-1:0]  psnr;
        logic               intra;
        logic [LAYER_W-1:0] layer;
    } frame_t;

    // What the block must report for one frame
    typedef struct packed {
        logic new_scene;
        logic refresh;
    } verdict_t;

    // Scoreboard: tracks cut history and refresh flags, queues the verdict of each frame
    class cut_scoreboard;
        logic [BD_W-1:0]     bit_depth = BIT_DEPTH_RST;
        logic [GOP_W-1:0]    gop_size  = GOP_SIZE_RST;
        logic [ACT_W-1:0]    prev_act  = '0;
        logic [PSNR_W-1:0]   prev_psnr = '0;
        longint              last_cut  = CUT_RESET_ORDER;
        logic [LEVELS-1:0]   refresh_flags = '0;
        verdict_t            expected_verdicts[$];
        int                  errors = 0;

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_BIT_DEPTH: bit_depth = data[BD_W-1:0];
                REG_GOP_SIZE:  gop_size  = data[GOP_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_frame(frame_t f);
            int unsigned     shift;
            longint unsigned dark_limit;
            int unsigned     act_now;
            int unsigned     act_prev;
            logic [PSNR_W-1:0] psnr_step;
            bit              jump;
            bit              dark;
            bit              intra_jump;
            bit              accept;
            verdict_t        v;

            act_now    = f.act;
            act_prev   = prev_act;
            shift      = (bit_depth >= LOW_ACT_BD_OFS) ? bit_depth - LOW_ACT_BD_OFS : 0;
            dark_limit = 64'd1 << shift;
            psnr_step  = (f.psnr >= prev_psnr) ? f.psnr - prev_psnr : prev_psnr - f.psnr;

            jump       = act_now * ACT_MUL_CUR > act_prev * ACT_MUL_PREV;
            dark       = (f.layer <= 1) && (f.act <= dark_limit);
            intra_jump = f.intra && (f.act > prev_act) && (psnr_step > PSNR_JUMP_Q8);
            accept     = (jump || dark || intra_jump)
                         && (longint'(f.order) >= last_cut + longint'(gop_size >> 1));

            if (accept)
            begin
                last_cut      = longint'(f.order);
                refresh_flags = '1;
            end
            prev_act = f.act;
            if (f.intra)
                prev_psnr = f.psnr;

            v.new_scene = accept;
            v.refresh   = 1'b0;
            if (f.layer < LEVELS)
            begin
                v.refresh = refresh_flags[f.layer];
                refresh_flags[f.layer] = 1'b0;
            end
            expected_verdicts.insert(expected_verdicts.size(), v);
        endfunction

        function void check_verdict(logic got_scene, logic got_refresh);
            verdict_t want;
            if (expected_verdicts.size() == 0)
            begin
                $display("%0t: result with none pending: new_scene=%0b refresh=%0b",
                         $time, got_scene, got_refresh);
                errors++;
                return;
            end
            want = expected_verdicts[0];
            expected_verdicts.delete(0);
            if (got_scene !== want.new_scene)
            begin
                $display("%0t: new_scene mismatch: expected %0b, actual %0b",
                         $time, want.new_scene, got_scene);
                errors++;
            end
            if (got_refresh !== want.refresh)
            begin
                $display("%0t: refresh mismatch: expected %0b, actual %0b",
                         $time, want.refresh, got_refresh);
                errors++;
            end
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_BIT_DEPTH;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    logic [ORDER_W-1:0]    pic_order = '0;
    logic [ACT_W-1:0]      activity  = '0;
    logic [PSNR_W-1:0]     psnr_q8   = '0;
    logic                  intra     = 1'b0;
    logic [LAYER_W-1:0]    layer     = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  new_scene;
    logic                  refresh;

    cut_scoreboard sb = new;

    int results_seen  = 0;
    int next_hold_at  = 40;
    int quiet_cycles  = 0;
    int burst_left    = 0;

    // stimulus cursor: the "scene" the random frames walk through
    logic [ORDER_W-1:0] stim_order = '0;
    logic [ACT_W-1:0]   stim_act   = 16'd3000;
    logic [PSNR_W-1:0]  stim_psnr  = 16'd9000;

    scene_cut_detector_unit #(.LEVELS(LEVELS)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .pic_order (pic_order),
        .activity  (activity),
        .psnr_q8   (psnr_q8),
        .intra     (intra),
        .layer     (layer),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .new_scene (new_scene),
        .refresh   (refresh)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Idle length: mostly zero or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Sender gaps, with occasional bursts of back-to-back transfers
    function automatic int sender_gap();
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 59) == 0)
        begin
            burst_left = $urandom_range(20, 80);
            return 0;
        end
        return pick_gap();
    endfunction

    // Random frame: mostly a plausible sequence (ascending order, activity drifting,
    // occasional cuts, dark frames and intra PSNR jumps), some pure noise.
    function automatic frame_t make_frame();
        frame_t f;
        int     r;
        int     span;
        int     a;
        r = $urandom_range(0, 99);
        if (r < 8)
        begin
            // noise: any field value, order jumps anywhere (also backward)
            f.order = ORDER_W'($urandom);
            f.act   = ACT_W'($urandom);
            f.psnr  = PSNR_W'($urandom);
            f.intra = 1'($urandom);
            f.layer = LAYER_W'($urandom);
            stim_order = f.order;
            return f;
        end
        stim_order += (r < 12) ? ORDER_W'(0) : ORDER_W'($urandom_range(1, 4));
        if (r < 22)
            stim_act = ACT_W'($urandom_range(0, 24));          // near-black frame
        else if (r < 32)
            stim_act = ACT_W'($urandom_range(0, 65535));       // likely a hard cut
        else
        begin
            span = stim_act / 8 + 3;
            a = int'(stim_act) + $urandom_range(0, 2 * span) - span;
            if (a < 0)
                a = 0;
            if (a > 65535)
                a = 65535;
            stim_act = ACT_W'(a);
        end
        f.order = stim_order;
        f.act   = stim_act;
        f.intra = ($urandom_range(0, 5) == 0);
        f.layer = LAYER_W'($urandom_range(0, 7));
        if (f.intra && $urandom_range(0, 3) != 0)
        begin
            // intra PSNR near the last one, straddling the 4.5 dB step
            a = int'(stim_psnr) + $urandom_range(0, 2800) - 1400;
            if (a < 0)
                a = 0;
            if (a > 65535)
                a = 65535;
            f.psnr = PSNR_W'(a);
        end
        else
            f.psnr = PSNR_W'($urandom);
        if (f.intra)
            stim_psnr = f.psnr;
        return f;
    endfunction

    // One input transfer; called right after a rising edge
    task automatic send_frame(frame_t f);
        in_valid  <= 1'b1;
        pic_order <= f.order;
        activity  <= f.act;
        psnr_q8   <= f.psnr;
        intra     <= f.intra;
        layer     <= f.layer;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_frame(f);
    endtask

    task automatic idle_input(int cycles);
        if (cycles > 0)
        begin
            in_valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    task automatic frame(logic [ORDER_W-1:0] order, logic [ACT_W-1:0] act,
                         logic [PSNR_W-1:0] psnr, logic is_intra, logic [LAYER_W-1:0] lyr);
        frame_t f;
        f.order = order;
        f.act   = act;
        f.psnr  = psnr;
        f.intra = is_intra;
        f.layer = lyr;
        idle_input(sender_gap());
        send_frame(f);
    endtask

    // Stop offering and wait until every result has come back
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Both registers, back to back; junk in the unused high bits of bit_depth
    task automatic write_config(int unsigned bd, int unsigned gop);
        logic [CFG_DATA_W-1:0] word;
        word = CFG_DATA_W'($urandom);
        word[BD_W-1:0] = bd[BD_W-1:0];
        cfg_we    <= 1'b1;
        cfg_index <= REG_BIT_DEPTH;
        cfg_data  <= word;
        @(posedge clk);
        sb.set_reg(REG_BIT_DEPTH, word);
        cfg_index <= REG_GOP_SIZE;
        cfg_data  <= gop[GOP_W-1:0];
        @(posedge clk);
        sb.set_reg(REG_GOP_SIZE, gop[GOP_W-1:0]);
        cfg_we <= 1'b0;
    endtask

    // Directed frames under the reset setting (threshold 16, cut spacing 16)
    task automatic directed_frames();
        frame(24'd0, 16'd0, 16'd0, 1'b0, 3'd0);              // dark frame, first cut
        frame(24'd1, 16'hFFFF, 16'hFFFF, 1'b1, 3'd7);        // huge jump, too close
        frame(24'd2, 16'd16, 16'd100, 1'b0, 3'd1);           // dark at the threshold
        frame(24'd3, 16'd17, 16'd100, 1'b0, 3'd1);           // just above threshold
        frame(24'd15, 16'd64, 16'd0, 1'b0, 3'd3);            // jump, one short of spacing
        frame(24'd16, 16'd181, 16'd0, 1'b0, 3'd4);           // ratio exactly 181/64: no cut
        frame(24'd16, 16'd512, 16'd0, 1'b0, 3'd5);           // just over ratio, at spacing
        frame(24'd17, 16'd182, 16'd0, 1'b0, 3'd0);           // flags read back per layer
        frame(24'd18, 16'd182, 16'd0, 1'b0, 3'd5);
        frame(24'd19, 16'd182, 16'd0, 1'b0, 3'd7);
        frame(24'd20, 16'd182, 16'd0, 1'b0, 3'd7);
        frame(24'd40, 16'd200, 16'd1000, 1'b1, 3'd6);        // intra PSNR jump
        frame(24'd60, 16'd201, 16'd2152, 1'b1, 3'd6);        // PSNR step exactly 4.5 dB
        frame(24'd61, 16'd202, 16'd3305, 1'b1, 3'd6);        // one step over 4.5 dB
        frame(24'd62, 16'd202, 16'd0, 1'b1, 3'd2);           // PSNR jump, flat activity
        frame(24'd5, 16'hFFFF, 16'd0, 1'b0, 3'd3);           // order going backward
        frame(24'hFFFFFF, 16'd0, 16'hFFFF, 1'b1, 3'd2);      // largest order
        frame(24'hAAAAAA, 16'd0, 16'h5555, 1'b0, 3'd1);      // dark cut, layer 1
        frame(24'h555555, 16'hAAAA, 16'hAAAA, 1'b0, 3'd0);   // backward, behind last cut
        frame(24'h555556, 16'h5555, 16'h5555, 1'b1, 3'd4);
    endtask

    // Result side: check every transfer against the oldest pending verdict
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            sb.check_verdict(new_scene, refresh);
            results_seen++;
        end
    end

    // Result side stall pattern; every HOLD_SPACING results one long hold-off
    // so the skid buffer fills and in_stall has to rise.
    initial
    begin : receiver
        int span;
        wait (rst_n);
        forever
        begin
            if (results_seen >= next_hold_at)
            begin
                next_hold_at += HOLD_SPACING;
                span = LONG_HOLD;
            end
            else
                span = pick_gap();
            if (span > 0)
            begin
                out_stall <= 1'b1;
                repeat (span) @(posedge clk);
            end
            out_stall <= 1'b0;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(40, 120)) @(posedge clk);
            else
                repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    // Watchdog: too long without any transfer on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // Settings: reset values first, then the extremes of both registers
    // (small and wide bit depth, zero and largest group size), last one random.
    initial
    begin : stimulus
        int unsigned setting_bd[NUM_SETTINGS];
        int unsigned setting_gop[NUM_SETTINGS];
        setting_bd  = '{10, 8, 16, 0, 31, 5, 22, 0};
        setting_gop = '{32, 1, 64, 0, 127, 2, 13, 0};
        setting_bd[NUM_SETTINGS-1]  = $urandom_range(0, 31);
        setting_gop[NUM_SETTINGS-1] = $urandom_range(0, 127);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int p = 0; p < NUM_SETTINGS; p++)
        begin
            if (p == 0)
                directed_frames();
            else
            begin
                drain();
                write_config(setting_bd[p], setting_gop[p]);
            end
            for (int i = 0; i < ITEMS_PER_SETTING; i++)
            begin
                idle_input(sender_gap());
                send_frame(make_frame());
            end
        end
        drain();

        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: scene_cut_detector_unit.f
+incdir+rtl/core
rtl/core/scd_pkg.sv
rtl/core/scene_cut_detector_unit.sv
tb/testbench.sv
